// File: hdl/nfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_pkg
// Shared types and constants of the nearest free cell ring search block.
// ----------------------------------------------------------------------------
package nfc_pkg;

  // signed grid coordinate, wide enough for rings that run past the grid
  localparam int CRD_W  = 9;
  // width of a cell coordinate on the ports
  localparam int CELL_W = 5;
  // width of the grid size registers
  localparam int REG_W  = 6;
  // configuration bus
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam int MAX_WIDTH_DEF  = 32;
  localparam int MAX_HEIGHT_DEF = 32;

  localparam logic [REG_W-1:0] RESET_DIM = 6'd32;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH
  } state_t;

  typedef enum logic {
    REQ_WRITE,
    REQ_SEARCH
  } req_t;

  typedef enum logic {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT
  } reg_idx_t;

  // grid size in use, already clamped
  typedef struct packed {
    crd_t w;
    crd_t h;
  } grid_t;

  // start of a ring: ok is low when the ring lies beyond the grid on every side
  typedef struct packed {
    logic ok;
    crd_t row;
    crd_t col;
  } pos_t;

  typedef struct packed {
    logic load;
    logic stop;
  } seq_ctl_t;

  typedef struct packed {
    logic rd_en;
    logic done;
    crd_t x;
    crd_t y;
  } seq_t;

endpackage

// File: hdl/nfc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module nfc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/nfc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_cfg
// Grid size registers on the APB port, with clamping to the supported range.
// ----------------------------------------------------------------------------
module nfc_cfg #(
  parameter int MAX_WIDTH  = nfc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = nfc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nfc_pkg::APB_AW-1:0]  paddr,
  input  logic [nfc_pkg::APB_DW-1:0]  pwdata,
  output logic [nfc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output nfc_pkg::grid_t              grid
);

  // largest grid size the registers can express and the map can hold
  localparam int REG_MAX = 2 ** nfc_pkg::REG_W - 1;
  localparam int W_LIM   = (MAX_WIDTH > REG_MAX) ? REG_MAX : MAX_WIDTH;
  localparam int H_LIM   = (MAX_HEIGHT > REG_MAX) ? REG_MAX : MAX_HEIGHT;

  logic [nfc_pkg::REG_W-1:0] width_r;
  logic [nfc_pkg::REG_W-1:0] width_nxt;
  logic [nfc_pkg::REG_W-1:0] height_r;
  logic [nfc_pkg::REG_W-1:0] height_nxt;
  nfc_pkg::reg_idx_t         idx;
  logic                      wr_en;

  assign pready = 1'b1;
  assign idx    = nfc_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      unique case (idx)
        nfc_pkg::REG_GRID_WIDTH:  width_nxt  = pwdata[nfc_pkg::REG_W-1:0];
        nfc_pkg::REG_GRID_HEIGHT: height_nxt = pwdata[nfc_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= nfc_pkg::RESET_DIM;
      height_r <= nfc_pkg::RESET_DIM;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      nfc_pkg::REG_GRID_WIDTH:  prdata = nfc_pkg::APB_DW'(width_r);
      nfc_pkg::REG_GRID_HEIGHT: prdata = nfc_pkg::APB_DW'(height_r);
      default:                  prdata = '0;
    endcase
  end

  // zero acts as one, anything above the map size acts as the map size
  always_comb begin
    if (width_r == '0) begin
      grid.w = nfc_pkg::crd_t'(1);
    end else if (32'(width_r) > W_LIM) begin
      grid.w = nfc_pkg::crd_t'(W_LIM);
    end else begin
      grid.w = nfc_pkg::crd_t'(width_r);
    end
    if (height_r == '0) begin
      grid.h = nfc_pkg::crd_t'(1);
    end else if (32'(height_r) > H_LIM) begin
      grid.h = nfc_pkg::crd_t'(H_LIM);
    end else begin
      grid.h = nfc_pkg::crd_t'(height_r);
    end
  end

endmodule

// File: hdl/nfc_ring_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_ring_seq
// Walks the border cells of growing square rings around a start cell, one
// position per cycle, skipping most of what lies outside the grid.
// ----------------------------------------------------------------------------
module nfc_ring_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nfc_pkg::seq_ctl_t            ctl,
  input  logic [nfc_pkg::CELL_W-1:0]   start_x,
  input  logic [nfc_pkg::CELL_W-1:0]   start_y,
  input  nfc_pkg::grid_t               grid,
  output nfc_pkg::seq_t                seq
);

  // first column visited in a row: whole span on top and bottom, sides otherwise
  function automatic nfc_pkg::crd_t first_col(
    nfc_pkg::crd_t r, nfc_pkg::crd_t x0, nfc_pkg::crd_t y0,
    nfc_pkg::crd_t x1, nfc_pkg::crd_t y1
  );
    logic is_edge;
    is_edge = (r == y0) || (r == y1);
    if (is_edge) begin
      return (x0 < 0) ? '0 : x0;
    end
    return (x0 >= 0) ? x0 : x1;
  endfunction

  function automatic nfc_pkg::pos_t ring_entry(
    nfc_pkg::crd_t x0, nfc_pkg::crd_t y0, nfc_pkg::crd_t x1, nfc_pkg::crd_t y1,
    nfc_pkg::crd_t w, nfc_pkg::crd_t h
  );
    nfc_pkg::pos_t p;
    nfc_pkg::crd_t r;
    p.ok = (x0 >= 0) || (y0 >= 0) || (x1 < w) || (y1 < h);
    r    = (y0 < 0) ? '0 : y0;
    // side rows with both sides off the grid hold nothing
    if ((r != y0) && (r != y1) && (x0 < 0) && (x1 >= w)) begin
      r = y1;
    end
    p.row = r;
    p.col = first_col(r, x0, y0, x1, y1);
    return p;
  endfunction

  nfc_pkg::crd_t x0_r, x0_nxt, y0_r, y0_nxt, x1_r, x1_nxt, y1_r, y1_nxt;
  nfc_pkg::crd_t row_r, row_nxt, col_r, col_nxt;
  logic          live_r, live_nxt, done_r, done_nxt;

  nfc_pkg::crd_t sx, sy;
  nfc_pkg::crd_t nx0, ny0, nx1, ny1;
  nfc_pkg::pos_t load_pos, next_pos;
  logic          in_grid, is_edge, col_step;
  nfc_pkg::crd_t col_next, nr_raw, nr;
  logic          jump, row_ok;

  assign sx = nfc_pkg::crd_t'({{(nfc_pkg::CRD_W-nfc_pkg::CELL_W){1'b0}}, start_x});
  assign sy = nfc_pkg::crd_t'({{(nfc_pkg::CRD_W-nfc_pkg::CELL_W){1'b0}}, start_y});

  assign nx0 = x0_r - nfc_pkg::crd_t'(1);
  assign ny0 = y0_r - nfc_pkg::crd_t'(1);
  assign nx1 = x1_r + nfc_pkg::crd_t'(1);
  assign ny1 = y1_r + nfc_pkg::crd_t'(1);

  assign load_pos = ring_entry(sx - nfc_pkg::crd_t'(1), sy - nfc_pkg::crd_t'(1),
                               sx + nfc_pkg::crd_t'(1), sy + nfc_pkg::crd_t'(1),
                               grid.w, grid.h);
  assign next_pos = ring_entry(nx0, ny0, nx1, ny1, grid.w, grid.h);

  assign in_grid = (row_r >= 0) && (row_r < grid.h) && (col_r >= 0) && (col_r < grid.w);
  assign is_edge = (row_r == y0_r) || (row_r == y1_r);

  always_comb begin
    if (is_edge) begin
      col_step = (col_r < x1_r) && ((col_r + nfc_pkg::crd_t'(1)) < grid.w);
      col_next = col_r + nfc_pkg::crd_t'(1);
    end else begin
      col_step = (col_r == x0_r) && (x1_r < grid.w);
      col_next = x1_r;
    end
  end

  assign nr_raw = row_r + nfc_pkg::crd_t'(1);
  assign jump   = (nr_raw != y1_r) && (x0_r < 0) && (x1_r >= grid.w);
  assign nr     = jump ? y1_r : nr_raw;
  assign row_ok = (nr_raw <= y1_r) && (nr < grid.h);

  always_comb begin
    x0_nxt   = x0_r;
    y0_nxt   = y0_r;
    x1_nxt   = x1_r;
    y1_nxt   = y1_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    live_nxt = live_r;
    done_nxt = done_r;
    if (ctl.stop) begin
      live_nxt = 1'b0;
      done_nxt = 1'b0;
    end else if (ctl.load) begin
      x0_nxt   = sx - nfc_pkg::crd_t'(1);
      y0_nxt   = sy - nfc_pkg::crd_t'(1);
      x1_nxt   = sx + nfc_pkg::crd_t'(1);
      y1_nxt   = sy + nfc_pkg::crd_t'(1);
      row_nxt  = load_pos.row;
      col_nxt  = load_pos.col;
      live_nxt = load_pos.ok;
      done_nxt = !load_pos.ok;
    end else if (live_r) begin
      if (col_step) begin
        col_nxt = col_next;
      end else if (row_ok) begin
        row_nxt = nr;
        col_nxt = first_col(nr, x0_r, y0_r, x1_r, y1_r);
      end else begin
        // ring finished, widen by one
        x0_nxt  = nx0;
        y0_nxt  = ny0;
        x1_nxt  = nx1;
        y1_nxt  = ny1;
        row_nxt = next_pos.row;
        col_nxt = next_pos.col;
        if (!next_pos.ok) begin
          live_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      live_r <= live_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x0_r  <= x0_nxt;
    y0_r  <= y0_nxt;
    x1_r  <= x1_nxt;
    y1_r  <= y1_nxt;
    row_r <= row_nxt;
    col_r <= col_nxt;
  end

  assign seq.rd_en = live_r & in_grid;
  assign seq.done  = done_r;
  assign seq.x     = col_r;
  assign seq.y     = row_r;

endmodule

// File: hdl/nearest_free_cell_ring_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_free_cell_ring_search
// Free/occupied cell map with a nearest free cell search over square rings.
// ----------------------------------------------------------------------------
// A write transaction gives its result in the cycle after it is taken; busy stays low.
// A search visits one map cell per cycle through the single read port of the map RAM,
// plus at most one skipped position per row of a ring; its result is registered from
// the map read of the last cell visited. busy is high for the whole search. After
// reset all MAX_WIDTH*MAX_HEIGHT map cells are swept to occupied with busy high.
// Results are shown for one cycle on out_valid and cannot be held off.
module nearest_free_cell_ring_search #(
  parameter int MAX_WIDTH  = nfc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = nfc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [nfc_pkg::CELL_W-1:0]  in_cell_x,
  input  logic [nfc_pkg::CELL_W-1:0]  in_cell_y,
  input  logic                        in_free_flag,
  output logic                        out_valid,
  output logic                        out_found,
  output logic [nfc_pkg::CELL_W-1:0]  out_found_x,
  output logic [nfc_pkg::CELL_W-1:0]  out_found_y,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nfc_pkg::APB_AW-1:0]  paddr,
  input  logic [nfc_pkg::APB_DW-1:0]  pwdata,
  output logic [nfc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  nfc_pkg::grid_t    grid;
  nfc_pkg::seq_t     seq;
  nfc_pkg::seq_ctl_t seq_ctl;
  nfc_pkg::state_t   state_r, state_nxt;

  logic [AW-1:0] clr_r, clr_nxt;
  logic          pend_r, pend_nxt;
  nfc_pkg::crd_t pend_x_r, pend_y_r;

  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r, out_found_nxt;
  logic [nfc_pkg::CELL_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr, wr_addr;
  logic [0:0]    ram_wdata, ram_rdata;

  logic          accept, is_search, wr_in_grid, hit, clr_last;
  logic [nfc_pkg::CRD_W-2:0] rd_row, rd_col;

  nfc_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .grid    (grid)
  );

  nfc_ring_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (seq_ctl),
    .start_x (in_cell_x),
    .start_y (in_cell_y),
    .grid    (grid),
    .seq     (seq)
  );

  nfc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != nfc_pkg::ST_IDLE);
  assign accept    = start & ~busy;
  assign is_search = (nfc_pkg::req_t'(in_req_type) == nfc_pkg::REQ_SEARCH);
  assign clr_last  = (clr_r == AW'(DEPTH - 1));

  assign wr_in_grid =
    (nfc_pkg::crd_t'({{(nfc_pkg::CRD_W-nfc_pkg::CELL_W){1'b0}}, in_cell_x}) < grid.w) &&
    (nfc_pkg::crd_t'({{(nfc_pkg::CRD_W-nfc_pkg::CELL_W){1'b0}}, in_cell_y}) < grid.h);
  assign wr_addr = AW'(32'(in_cell_y) * 32'(MAX_WIDTH) + 32'(in_cell_x));

  // position is known to be inside the grid whenever rd_en is high
  assign rd_row    = seq.y[nfc_pkg::CRD_W-2:0];
  assign rd_col    = seq.x[nfc_pkg::CRD_W-2:0];
  assign ram_raddr = AW'(32'(rd_row) * 32'(MAX_WIDTH) + 32'(rd_col));

  assign hit = pend_r & ram_rdata[0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nfc_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = nfc_pkg::ST_IDLE;
        end
      end
      nfc_pkg::ST_IDLE: begin
        if (accept && is_search) begin
          state_nxt = nfc_pkg::ST_SEARCH;
        end
      end
      nfc_pkg::ST_SEARCH: begin
        if (hit || seq.done) begin
          state_nxt = nfc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nfc_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = clr_r;
    ram_wdata     = 1'b0;
    ram_re        = 1'b0;
    seq_ctl       = '0;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = 1'b0;
    out_x_nxt     = '0;
    out_y_nxt     = '0;
    unique case (state_r)
      nfc_pkg::ST_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
      end
      nfc_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_search) begin
            seq_ctl.load = 1'b1;
          end else begin
            out_valid_nxt = 1'b1;
            if (wr_in_grid) begin
              ram_we    = 1'b1;
              ram_waddr = wr_addr;
              ram_wdata = in_free_flag;
            end
          end
        end
      end
      nfc_pkg::ST_SEARCH: begin
        ram_re = seq.rd_en;
        if (hit) begin
          seq_ctl.stop  = 1'b1;
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_x_nxt     = pend_x_r[nfc_pkg::CELL_W-1:0];
          out_y_nxt     = pend_y_r[nfc_pkg::CELL_W-1:0];
        end else if (seq.done) begin
          seq_ctl.stop  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign pend_nxt = ram_re;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfc_pkg::ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      pend_x_r <= seq.x;
      pend_y_r <= seq.y;
    end
    if (out_valid_nxt) begin
      out_found_r <= out_found_nxt;
      out_x_r     <= out_x_nxt;
      out_y_r     <= out_y_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_found_x = out_x_r;
  assign out_found_y = out_y_r;

endmodule
